/* hdl/sobel_edge_inverted_unit_macros.svh */
// Assertion macros shared by the RTL of the inverted Sobel edge unit.
`ifndef SOBEL_EDGE_INVERTED_UNIT_MACROS_SVH
`define SOBEL_EDGE_INVERTED_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SEI_ASSERT_IMPL(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SEI_ASSERT_NEXT(label, ck, rn, ante, cons, msg) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/sei_pkg.sv */
// Types and constants of the inverted Sobel edge unit.
`default_nettype none

package sei_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int WIDTH_W        = 11;
    localparam int HEIGHT_W       = 16;
    localparam int CFG_DATA_W     = 16;
    localparam int PIX_W          = 8;
    localparam int OUT_FIFO_DEPTH = 4;

    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;
    localparam logic [PIX_W-1:0]    PIX_MAX      = 8'd255;

    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef enum logic [0:0] {
        KIND_PIXEL = 1'b0,
        KIND_FLUSH = 1'b1
    } kind_t;

endpackage

`default_nettype wire

/* hdl/sei_ram.sv */
// Generic simple dual-port RAM, one write port, one registered read port.
`default_nettype none

module sei_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read at the write address returns the old word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/sobel_edge_inverted_unit.sv */
// Top level of the inverted 3x3 Sobel edge unit for raster pixel streams.
//
// Channel   Dir  Handshake              Payload
// ------    ---  ---------------------  ------------------------------------
// in        in   in_valid / in_ready    kind, pixel
// out       out  out_valid / out_ready  edge_value, last
// cfg       in   cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// One beat per clock on the input while in_ready is high; a result passes
// the stage B and C registers, then leaves through a 4-entry output FIFO.
// The rate is set by the line store RAM: one read at accept, one write in
// the cycle after, with a bypass for back-to-back hits on the same column.
// After reset a clearing pass zeroes all MAX_WIDTH columns (1024 by default)
// of both line stores; in_ready stays low meanwhile, cfg writes still land.
// in_ready drops while the FIFO plus the results in flight hold 4 entries.
`default_nettype none

module sobel_edge_inverted_unit #(
    parameter int MAX_WIDTH = sei_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input beats
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire sei_pkg::kind_t                     kind,
    input  wire logic [sei_pkg::PIX_W-1:0]          pixel,
    // result beats
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic      [sei_pkg::PIX_W-1:0]          edge_value,
    output logic                                    last,
    // register writes
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire sei_pkg::reg_idx_t                  cfg_index,
    input  wire logic [sei_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import sei_pkg::*;
    `include "sobel_edge_inverted_unit_macros.svh"

    // column counters address the line stores
    localparam int CW    = $clog2(MAX_WIDTH);
    // common width for column vs. image width compares
    localparam int EW    = ($clog2(MAX_WIDTH + 1) > WIDTH_W) ? $clog2(MAX_WIDTH + 1) : WIDTH_W;
    localparam int RW    = HEIGHT_W;
    localparam int LW    = 2 * PIX_W;   // {row_two_above, row_above}
    localparam int PTR_W = $clog2(OUT_FIFO_DEPTH);
    localparam int FCW   = $clog2(OUT_FIFO_DEPTH + 1);

    localparam logic [EW-1:0]  MAXW_E   = EW'(MAX_WIDTH);
    localparam logic [CW-1:0]  LAST_COL = CW'(MAX_WIDTH - 1);
    localparam logic [FCW:0]   FDEPTH   = (FCW + 1)'(OUT_FIFO_DEPTH);
    localparam logic [FCW-1:0] FFULL    = FCW'(OUT_FIFO_DEPTH);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    // effective frame size: zero reads as one, width capped at the store depth
    logic [EW-1:0] w_ext;
    logic [EW-1:0] w_eff;
    logic [RW-1:0] h_eff;

    assign w_ext = EW'(width_reg);
    assign w_eff = (w_ext == '0) ? EW'(1) : ((w_ext > MAXW_E) ? MAXW_E : w_ext);
    assign h_eff = (height_reg == '0) ? RW'(1) : height_reg;

    // ---------------------------------------------------------------
    // line store clearing pass after reset
    // ---------------------------------------------------------------
    logic          clr_busy_reg;
    logic [CW-1:0] clr_addr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + CW'(1);
            if (clr_addr_reg == LAST_COL)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // stage A: accept, position bookkeeping, line store read
    // ---------------------------------------------------------------
    logic [CW-1:0] in_col_reg,  in_col_next;
    logic [RW-1:0] in_row_reg,  in_row_next;
    logic [CW-1:0] out_col_reg, out_col_next;
    logic [RW-1:0] out_row_reg, out_row_next;

    logic          in_fire;
    logic [EW-1:0] in_col_p1;
    logic [EW-1:0] out_col_p1;
    logic [RW:0]   out_row_p1;
    logic          col_wrap;
    logic          row_drain;
    logic          o_col_end;
    logic          o_row_end;
    logic          a_proc;
    logic          a_emit;
    logic          a_last;
    logic          a_interior;
    logic          win_filled;

    assign in_fire    = in_valid && in_ready;
    assign in_col_p1  = EW'(in_col_reg) + EW'(1);
    assign out_col_p1 = EW'(out_col_reg) + EW'(1);
    assign out_row_p1 = {1'b0, out_row_reg} + (RW + 1)'(1);
    assign col_wrap   = in_col_p1 >= w_eff;
    // all pixels of the frame are in: every beat drains one border result
    assign row_drain  = in_row_reg >= h_eff;
    assign o_col_end  = out_col_p1 >= w_eff;
    assign o_row_end  = out_row_p1 >= {1'b0, h_eff};

    // a flush beat mid-frame does nothing
    assign a_proc     = !row_drain && (kind == KIND_PIXEL);
    assign win_filled = (in_row_reg >= RW'(2)) || ((in_row_reg == RW'(1)) && (in_col_reg != '0));
    assign a_emit     = row_drain || (a_proc && win_filled);
    assign a_last     = o_row_end && o_col_end;
    assign a_interior = a_proc && !(out_row_reg == '0 || o_row_end ||
                                    out_col_reg == '0 || o_col_end);

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (in_fire && a_proc)
        begin
            if (col_wrap)
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end
            else
            begin
                in_col_next = in_col_p1[CW-1:0];
            end
        end
        if (in_fire && a_emit)
        begin
            if (a_last)
            begin
                // frame done: all four counters restart
                in_col_next  = '0;
                in_row_next  = '0;
                out_col_next = '0;
                out_row_next = '0;
            end
            else if (o_col_end)
            begin
                out_col_next = '0;
                out_row_next = out_row_p1[RW-1:0];
            end
            else
            begin
                out_col_next = out_col_p1[CW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else
        begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

    // ---------------------------------------------------------------
    // line stores: one RAM, each word holds both rows of a column
    // ---------------------------------------------------------------
    logic          ram_we;
    logic [CW-1:0] ram_waddr;
    logic [LW-1:0] ram_wdata;
    logic [LW-1:0] ram_rdata;
    logic [LW-1:0] st_word;

    sei_ram #(
        .WIDTH (LW),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_fire && a_proc),
        .raddr (in_col_reg),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------------------
    // stage B: window shift and line store write-back (never stalls)
    // ---------------------------------------------------------------
    logic             b_proc_reg;
    logic             b_emit_reg;
    logic             b_interior_reg;
    logic             b_last_reg;
    logic [PIX_W-1:0] b_pix_reg;
    logic [CW-1:0]    b_col_reg;

    // bypass for the write that landed on the same edge as this beat's read
    logic             lw_valid_reg;
    logic [CW-1:0]    lw_addr_reg;
    logic [LW-1:0]    lw_data_reg;
    logic             fwd_hit;
    logic [PIX_W-1:0] two_above;
    logic [PIX_W-1:0] above;

    logic [PIX_W-1:0] win_reg [9];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_proc_reg   <= 1'b0;
            b_emit_reg   <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else
        begin
            b_proc_reg   <= in_fire && a_proc;
            b_emit_reg   <= in_fire && a_emit;
            lw_valid_reg <= b_proc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_interior_reg <= a_interior;
        b_last_reg     <= a_last;
        b_pix_reg      <= pixel;
        b_col_reg      <= in_col_reg;
        lw_addr_reg    <= b_col_reg;
        lw_data_reg    <= st_word;
    end

    assign fwd_hit   = lw_valid_reg && (lw_addr_reg == b_col_reg);
    assign two_above = fwd_hit ? lw_data_reg[LW-1:PIX_W] : ram_rdata[LW-1:PIX_W];
    assign above     = fwd_hit ? lw_data_reg[PIX_W-1:0]  : ram_rdata[PIX_W-1:0];
    // row_two_above takes row_above, row_above takes the new pixel
    assign st_word   = {above, b_pix_reg};

    assign ram_we    = clr_busy_reg || b_proc_reg;
    assign ram_waddr = clr_busy_reg ? clr_addr_reg : b_col_reg;
    assign ram_wdata = clr_busy_reg ? '0 : st_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (b_proc_reg)
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= two_above;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= above;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= b_pix_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage C: Sobel magnitude, clamp and invert, push into the FIFO
    // ---------------------------------------------------------------
    logic c_emit_reg;
    logic c_interior_reg;
    logic c_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_emit_reg <= 1'b0;
        end
        else
        begin
            c_emit_reg <= b_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_interior_reg <= b_interior_reg;
        c_last_reg     <= b_last_reg;
    end

    logic [9:0]       gx_pos, gx_neg, gy_pos, gy_neg;
    logic [9:0]       gx_abs, gy_abs;
    logic [10:0]      mag;
    logic [PIX_W-1:0] mag_clamp;
    logic [PIX_W-1:0] c_value;

    assign gx_pos = 10'(win_reg[2]) + {1'b0, win_reg[5], 1'b0} + 10'(win_reg[8]);
    assign gx_neg = 10'(win_reg[0]) + {1'b0, win_reg[3], 1'b0} + 10'(win_reg[6]);
    assign gy_pos = 10'(win_reg[6]) + {1'b0, win_reg[7], 1'b0} + 10'(win_reg[8]);
    assign gy_neg = 10'(win_reg[0]) + {1'b0, win_reg[1], 1'b0} + 10'(win_reg[2]);
    assign gx_abs = (gx_pos >= gx_neg) ? (gx_pos - gx_neg) : (gx_neg - gx_pos);
    assign gy_abs = (gy_pos >= gy_neg) ? (gy_pos - gy_neg) : (gy_neg - gy_pos);
    assign mag    = 11'(gx_abs) + 11'(gy_abs);
    assign mag_clamp = (mag > 11'(PIX_MAX)) ? PIX_MAX : mag[PIX_W-1:0];
    // border and drained results are plain white
    assign c_value   = c_interior_reg ? (PIX_MAX - mag_clamp) : PIX_MAX;

    // ---------------------------------------------------------------
    // output FIFO
    // ---------------------------------------------------------------
    logic [PIX_W-1:0] fifo_val_reg  [OUT_FIFO_DEPTH];
    logic             fifo_last_reg [OUT_FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [FCW-1:0]   fifo_count_reg;
    logic             push;
    logic             pop;
    logic [FCW:0]     occupancy;

    assign push = c_emit_reg;
    assign pop  = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_val_reg[wr_ptr_reg]  <= c_value;
            fifo_last_reg[wr_ptr_reg] <= c_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            fifo_count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            case ({push, pop})
                2'b10:   fifo_count_reg <= fifo_count_reg + FCW'(1);
                2'b01:   fifo_count_reg <= fifo_count_reg - FCW'(1);
                default: ;
            endcase
        end
    end

    assign out_valid  = fifo_count_reg != '0;
    assign edge_value = fifo_val_reg[rd_ptr_reg];
    assign last       = fifo_last_reg[rd_ptr_reg];

    // room for every result still in flight plus one more
    assign occupancy = {1'b0, fifo_count_reg} + (FCW + 1)'(b_emit_reg) + (FCW + 1)'(c_emit_reg);
    assign in_ready  = !clr_busy_reg && (occupancy < FDEPTH);

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `SEI_ASSERT_IMPL(a_no_accept_in_clear, clk, rst_n, clr_busy_reg, !in_ready,
        "beat accepted during line store clearing")
    `SEI_ASSERT_IMPL(a_fifo_no_overflow, clk, rst_n, push && !pop, fifo_count_reg != FFULL,
        "result pushed into a full output FIFO")
    `SEI_ASSERT_NEXT(a_pixel_writes_store, clk, rst_n, in_fire && a_proc,
        ram_we && !clr_busy_reg && (ram_waddr == $past(in_col_reg)),
        "accepted pixel did not write back its line store column")
    `SEI_ASSERT_NEXT(a_last_restarts_frame, clk, rst_n, in_fire && a_emit && a_last,
        (out_col_reg == '0) && (out_row_reg == '0) && (in_row_reg == '0),
        "frame counters not restarted after the last result")

endmodule

`default_nettype wire
